[rtl/cmc_pkg.sv]
// Shared constants, types and helper functions for the pad merge charge centroid block.
package cmc_pkg;

    localparam int unsigned COLUMNS_DEF = 300;
    localparam int unsigned ROWS        = 10;
    localparam int unsigned PADS        = 5;
    localparam int unsigned PAD_IDX_W   = $clog2(PADS);
    localparam int unsigned ROW_W       = 16;
    localparam int unsigned SUM_W       = 26;
    localparam int unsigned TOT_W       = SUM_W + 3;
    localparam int unsigned CTR_W       = 9;
    localparam int unsigned WGT_W       = SUM_W + CTR_W + 3;
    localparam int unsigned DIV_W       = WGT_W;
    localparam int unsigned QUO_W       = 20;
    localparam int unsigned STEP_W      = $clog2(QUO_W + 1);
    localparam int unsigned CFG_W       = 9;
    localparam int unsigned CFG_SPAN    = 2 ** CFG_W;
    localparam int unsigned X_W         = 10;
    localparam int unsigned Y_W         = 14;
    localparam int unsigned E_W         = 20;
    localparam int unsigned GI_W        = 9;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned ADDR_W      = 3;

    localparam logic [CFG_W-1:0]  FALLBACK_GROUP = CFG_W'(10);
    localparam int unsigned       HALF_PITCH_UM  = 25;
    localparam int unsigned       COL_PITCH_UM   = 50;
    localparam logic signed [X_W-1:0] EMPTY_X_UM = -X_W'(100);
    localparam logic [STEP_W-1:0] X_STEPS        = STEP_W'(9);
    localparam logic [STEP_W-1:0] E_STEPS        = STEP_W'(QUO_W);

    localparam logic REG_COLS_PER_GROUP = 1'b0;

    typedef struct packed {
        logic add;
        logic clr;
    } t_lane_ctl;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    function automatic logic [CTR_W-1:0] pad_centre(input logic [PAD_IDX_W-1:0] idx);
        logic [CTR_W-1:0] c;
        case (idx)
            3'd0:    c = CTR_W'(25);
            3'd1:    c = CTR_W'(125);
            3'd2:    c = CTR_W'(225);
            3'd3:    c = CTR_W'(325);
            3'd4:    c = CTR_W'(425);
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CFG_SPAN-1:0] divisor_mask(input int unsigned cols);
        logic [CFG_SPAN-1:0] m;
        int unsigned         acc;
        m = '0;
        for (int unsigned r = 1; r < CFG_SPAN; r++) begin
            acc = r;
            while (acc < cols) begin
                acc = acc + r;
            end
            m[r] = (acc == cols);
        end
        return m;
    endfunction

endpackage

[rtl/pad_merge_charge_centroid.sv]
// Top level of the pad merge charge centroid block: lanes, merge, divider and control.
//
// Input channel (i_valid / o_stall) carries one pixel column of ten row
// charges per word; output channel (o_valid / i_stall) carries one hit per
// completed column group. Row pairs feed five pad lanes that accumulate in
// parallel, one column per cycle while o_stall is low. The cols_per_group
// register at byte address 0 is sampled when the first column of a track
// arrives; a value that is zero or does not divide COLUMNS selects groups
// of ten. A column that does not close a group does not stall the input.
// The column that closes a group holds the input while the merge stage
// walks the five lanes, the shared divider forms the x centroid and then
// the charge per column, and the output register is loaded; the load waits
// while that register holds a hit that a stalled receiver has not taken.
// An empty group skips the divider. Columns past the last whole group of
// a track are consumed without effect. The hit sits in an output register,
// so the next column is taken while it waits; a stalled receiver blocks
// the block only when a second hit is ready. Reset clears the pad sums,
// the counters and the output valid, and loads a group size of ten.
module pad_merge_charge_centroid #(
    parameter int unsigned COLUMNS = cmc_pkg::COLUMNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row0,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row1,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row2,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row3,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row4,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row5,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row6,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row7,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row8,
    input  logic [cmc_pkg::ROW_W-1:0]          i_charge_row9,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [cmc_pkg::X_W-1:0]     o_x_um,
    output logic [cmc_pkg::Y_W-1:0]            o_y_um,
    output logic [cmc_pkg::E_W-1:0]            o_energy_per_col,
    output logic                               o_hit_found,
    output logic [cmc_pkg::GI_W-1:0]           o_group_index,
    output logic                               o_last_of_track,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cmc_pkg::ADDR_W-1:0]         paddr,
    input  logic [cmc_pkg::DATA_W-1:0]         pwdata,
    output logic [cmc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int unsigned CW = $clog2(COLUMNS);
    localparam int unsigned SW = ((CW > cmc_pkg::CFG_W) ? CW : cmc_pkg::CFG_W) + 2;
    localparam logic [cmc_pkg::CFG_SPAN-1:0] DIV_MASK = cmc_pkg::divisor_mask(COLUMNS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MERGE = 5'b00010,
        ST_DIVX  = 5'b00100,
        ST_DIVE  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;

    logic [cmc_pkg::CFG_W-1:0]     r_cols_per_group;
    logic [cmc_pkg::CFG_W-1:0]     r_cfg_eff;
    logic [cmc_pkg::CFG_W-1:0]     r_group_size;
    logic [cmc_pkg::CFG_W-1:0]     r_cig;
    logic [CW-1:0]                 r_cit;
    logic [CW-1:0]                 r_gc;

    logic [cmc_pkg::GI_W-1:0]      r_h_gi;
    logic                          r_h_last;
    logic [cmc_pkg::CFG_W-1:0]     r_h_g;
    logic [cmc_pkg::Y_W-1:0]       r_h_y;
    logic signed [cmc_pkg::X_W-1:0] r_h_x;
    logic [cmc_pkg::E_W-1:0]       r_h_e;
    logic                          r_h_found;

    logic                          r_out_valid;
    logic signed [cmc_pkg::X_W-1:0] r_o_x;
    logic [cmc_pkg::Y_W-1:0]       r_o_y;
    logic [cmc_pkg::E_W-1:0]       r_o_e;
    logic                          r_o_found;
    logic [cmc_pkg::GI_W-1:0]      r_o_gi;
    logic                          r_o_last;

    logic                          cfg_wr;
    logic                          accept;
    logic [cmc_pkg::CFG_W-1:0]     g_cur;
    logic                          fits;
    logic                          active;
    logic                          group_end;
    logic                          track_end;
    logic                          last_group;
    logic [cmc_pkg::Y_W-1:0]       y_base;
    logic [cmc_pkg::Y_W-1:0]       y_cur;

    logic [cmc_pkg::ROW_W-1:0]     rows [cmc_pkg::ROWS];
    logic [cmc_pkg::SUM_W-1:0]     sums [cmc_pkg::PADS];
    cmc_pkg::t_lane_ctl            lane_ctl;

    logic                          merge_busy;
    logic [cmc_pkg::TOT_W-1:0]     total;
    logic [cmc_pkg::WGT_W-1:0]     weighted;

    cmc_pkg::t_div_req             div_req;
    logic [cmc_pkg::DIV_W-1:0]     div_num;
    logic [cmc_pkg::DIV_W-1:0]     div_den;
    logic                          div_busy;
    logic [cmc_pkg::QUO_W-1:0]     div_quo;
    logic                          out_load;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == cmc_pkg::REG_COLS_PER_GROUP);
    assign prdata = (paddr[2] == cmc_pkg::REG_COLS_PER_GROUP)
                    ? cmc_pkg::DATA_W'(r_cols_per_group) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_per_group <= cmc_pkg::FALLBACK_GROUP;
            r_cfg_eff        <= cmc_pkg::FALLBACK_GROUP;
        end else if (cfg_wr) begin
            r_cols_per_group <= pwdata[cmc_pkg::CFG_W-1:0];
            r_cfg_eff        <= DIV_MASK[pwdata[cmc_pkg::CFG_W-1:0]]
                                ? pwdata[cmc_pkg::CFG_W-1:0] : cmc_pkg::FALLBACK_GROUP;
        end
    end

    // column bookkeeping
    assign o_stall    = (r_state != ST_IDLE);
    assign accept     = i_valid && !o_stall;
    assign g_cur      = (r_cit == '0) ? r_cfg_eff : r_group_size;
    assign fits       = (SW'(r_cit) + SW'(g_cur)) <= SW'(COLUMNS);
    assign active     = (r_cig == '0) ? fits : 1'b1;
    assign group_end  = active
                        && (({1'b0, r_cig} + 1'b1) == {1'b0, g_cur});
    assign track_end  = (r_cit == CW'(COLUMNS - 1));
    assign last_group = (SW'(r_cit) + SW'(g_cur) + 1'b1) > SW'(COLUMNS);
    assign y_base     = cmc_pkg::Y_W'(cmc_pkg::HALF_PITCH_UM)
                        + cmc_pkg::Y_W'(cmc_pkg::COL_PITCH_UM * r_gc);
    assign y_cur      = cmc_pkg::Y_W'(y_base * g_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= cmc_pkg::FALLBACK_GROUP;
            r_cig        <= '0;
            r_cit        <= '0;
            r_gc         <= '0;
        end else if (accept) begin
            if (r_cit == '0) begin
                r_group_size <= r_cfg_eff;
            end
            if (group_end) begin
                r_cig <= '0;
                r_gc  <= r_gc + 1'b1;
            end else if (active) begin
                r_cig <= r_cig + 1'b1;
            end
            if (track_end) begin
                r_cit <= '0;
                r_cig <= '0;
                r_gc  <= '0;
            end else begin
                r_cit <= r_cit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && group_end) begin
            r_h_gi   <= cmc_pkg::GI_W'(r_gc);
            r_h_last <= last_group;
            r_h_g    <= g_cur;
            r_h_y    <= y_cur;
        end
    end

    // pad lanes
    assign rows[0] = i_charge_row0;
    assign rows[1] = i_charge_row1;
    assign rows[2] = i_charge_row2;
    assign rows[3] = i_charge_row3;
    assign rows[4] = i_charge_row4;
    assign rows[5] = i_charge_row5;
    assign rows[6] = i_charge_row6;
    assign rows[7] = i_charge_row7;
    assign rows[8] = i_charge_row8;
    assign rows[9] = i_charge_row9;

    assign lane_ctl.add = accept && active;
    assign lane_ctl.clr = (r_state == ST_MERGE) && !merge_busy;

    for (genvar p = 0; p < cmc_pkg::PADS; p++) begin : g_lane
        cmc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_row_a (rows[2*p]),
            .i_row_b (rows[2*p+1]),
            .o_sum   (sums[p])
        );
    end

    cmc_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && group_end),
        .i_sums     (sums),
        .o_busy     (merge_busy),
        .o_total    (total),
        .o_weighted (weighted)
    );

    // divider sequencing
    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = cmc_pkg::X_STEPS;
        div_num       = weighted;
        div_den       = cmc_pkg::DIV_W'(total);
        case (r_state)
            ST_MERGE: begin
                div_req.start = !merge_busy && (total != '0);
            end
            ST_DIVX: begin
                div_req.start = !div_busy;
                div_req.steps = cmc_pkg::E_STEPS;
                div_num       = cmc_pkg::DIV_W'(total);
                div_den       = cmc_pkg::DIV_W'(r_h_g);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    cmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && group_end) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (!merge_busy) begin
                    n_state = (total != '0) ? ST_DIVX : ST_DONE;
                end
            end
            ST_DIVX: begin
                if (!div_busy) begin
                    n_state = ST_DIVE;
                end
            end
            ST_DIVE: begin
                if (!div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MERGE: begin
                if (!merge_busy) begin
                    r_h_found <= (total != '0);
                    r_h_x     <= cmc_pkg::EMPTY_X_UM;
                    r_h_e     <= '0;
                end
            end
            ST_DIVX: begin
                if (!div_busy) begin
                    r_h_x <= cmc_pkg::X_W'(div_quo);
                end
            end
            ST_DIVE: begin
                if (!div_busy) begin
                    r_h_e <= cmc_pkg::E_W'(div_quo);
                end
            end
            default: begin
                r_h_found <= r_h_found;
            end
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_x     <= r_h_x;
            r_o_y     <= r_h_y;
            r_o_e     <= r_h_e;
            r_o_found <= r_h_found;
            r_o_gi    <= r_h_gi;
            r_o_last  <= r_h_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_x_um           = r_o_x;
    assign o_y_um           = r_o_y;
    assign o_energy_per_col = r_o_e;
    assign o_hit_found      = r_o_found;
    assign o_group_index    = r_o_gi;
    assign o_last_of_track  = r_o_last;

endmodule

[rtl/cmc_lane.sv]
// One pad lane: merges a row pair and accumulates the pad charge over a group.
module cmc_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmc_pkg::t_lane_ctl          i_ctl,
    input  logic [cmc_pkg::ROW_W-1:0]   i_row_a,
    input  logic [cmc_pkg::ROW_W-1:0]   i_row_b,
    output logic [cmc_pkg::SUM_W-1:0]   o_sum
);

    logic [cmc_pkg::SUM_W-1:0] r_sum;
    logic [cmc_pkg::SUM_W-1:0] n_sum;
    logic [cmc_pkg::ROW_W:0]   pair;

    assign pair = {1'b0, i_row_a} + {1'b0, i_row_b};

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clr) begin
            n_sum = '0;
        end else if (i_ctl.add) begin
            n_sum = r_sum + cmc_pkg::SUM_W'(pair);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[rtl/cmc_merge.sv]
// Merge stage: walks the lanes and forms the group total and position-weighted sum.
module cmc_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cmc_pkg::SUM_W-1:0]   i_sums [cmc_pkg::PADS],
    output logic                        o_busy,
    output logic [cmc_pkg::TOT_W-1:0]   o_total,
    output logic [cmc_pkg::WGT_W-1:0]   o_weighted
);

    logic                            r_busy;
    logic [cmc_pkg::PAD_IDX_W-1:0]   r_idx;
    logic [cmc_pkg::TOT_W-1:0]       r_total;
    logic [cmc_pkg::WGT_W-1:0]       r_weighted;
    logic [cmc_pkg::SUM_W-1:0]       cur;
    logic [cmc_pkg::SUM_W+cmc_pkg::CTR_W-1:0] prod;

    assign cur  = i_sums[r_idx];
    assign prod = cur * cmc_pkg::pad_centre(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (r_idx == cmc_pkg::PAD_IDX_W'(cmc_pkg::PADS - 1)) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_total    <= '0;
            r_weighted <= '0;
        end else if (r_busy) begin
            r_total    <= r_total + cmc_pkg::TOT_W'(cur);
            r_weighted <= r_weighted + cmc_pkg::WGT_W'(prod);
        end
    end

    assign o_busy     = r_busy;
    assign o_total    = r_total;
    assign o_weighted = r_weighted;

endmodule

[rtl/cmc_div.sv]
// Shared restoring divider, one quotient bit per cycle, for a known quotient width.
module cmc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmc_pkg::t_div_req           i_req,
    input  logic [cmc_pkg::DIV_W-1:0]   i_num,
    input  logic [cmc_pkg::DIV_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [cmc_pkg::QUO_W-1:0]   o_quo
);

    logic [cmc_pkg::STEP_W-1:0] r_cnt;
    logic [cmc_pkg::DIV_W-1:0]  r_rem;
    logic [cmc_pkg::DIV_W-1:0]  r_den;
    logic [cmc_pkg::QUO_W-1:0]  r_quo;
    logic                       fit;

    assign fit = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_num;
            r_den <= i_den << (i_req.steps - 1'b1);
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            if (fit) begin
                r_rem <= r_rem - r_den;
            end
            r_den <= r_den >> 1;
            r_quo <= {r_quo[cmc_pkg::QUO_W-2:0], fit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

[rtl/cmc_checker.sv]
// Port-level checker for the pad merge charge centroid block, bound to its top level.
module cmc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic signed [cmc_pkg::X_W-1:0]   o_x_um,
    input logic [cmc_pkg::Y_W-1:0]          o_y_um,
    input logic [cmc_pkg::E_W-1:0]          o_energy_per_col,
    input logic                             o_hit_found
);

    a_empty_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_found |-> (o_x_um == cmc_pkg::EMPTY_X_UM)
                                    && (o_energy_per_col == '0))
        else $error("empty group word carries position or energy");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit_found |-> (o_x_um >= 10'sd25) && (o_x_um <= 10'sd425))
        else $error("centroid outside the pad centres");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_um) && $stable(o_y_um)
                               && $stable(o_energy_per_col) && $stable(o_hit_found))
        else $error("stalled output word changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind pad_merge_charge_centroid cmc_checker u_cmc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_x_um           (o_x_um),
    .o_y_um           (o_y_um),
    .o_energy_per_col (o_energy_per_col),
    .o_hit_found      (o_hit_found)
);
